// ===== rtl/stu_pkg.sv =====
// Shared package of the source tokenizer: token codes, the keyword table and
// the token and queue entry types.
// No dependencies.
package stu_pkg;

	localparam longint unsigned SOURCE_BYTES_DEF = 64'd1048576;
	localparam int unsigned KW_MAX_DEF = 7;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] TK_IDENT = 4'd0;
	localparam logic [3:0] TK_KEYWORD = 4'd1;
	localparam logic [3:0] TK_NUMBER = 4'd2;
	localparam logic [3:0] TK_OPER = 4'd3;
	localparam logic [3:0] TK_SEMI = 4'd4;
	localparam logic [3:0] TK_ASSIGN = 4'd5;
	localparam logic [3:0] TK_LCURLY = 4'd6;
	localparam logic [3:0] TK_RCURLY = 4'd7;
	localparam logic [3:0] TK_LPAREN = 4'd8;
	localparam logic [3:0] TK_RPAREN = 4'd9;
	localparam logic [3:0] TK_COMMA = 4'd10;
	localparam logic [3:0] TK_QUOTE = 4'd11;
	localparam logic [3:0] TK_END = 4'd12;
	localparam logic [3:0] TK_ERROR = 4'd13;

	localparam logic [2:0] OP_PLUS = 3'd0;
	localparam logic [2:0] OP_MINUS = 3'd1;
	localparam logic [2:0] OP_MULT = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] SUB_NONE = 3'd0;

	localparam int KW_COUNT = 6;
	localparam int KW_SPAN = 7;
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SPAN] = '{
		'{"r", "e", "t", "u", "r", "n", 8'h00},
		'{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00},
		'{"_", "_", "a", "s", "m", "_", "_"}
	};
	localparam int KW_LEN [KW_COUNT] = '{6, 3, 3, 2, 5, 7};

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  sub;
		logic [19:0] start;
		logic [20:0] length;
		logic [63:0] value;
		logic        last;
	} tok_t;

	typedef struct packed {
		tok_t [2:0] tok;
		logic [1:0] count;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} push_t;

endpackage

// ===== rtl/stu_if.sv =====
// Channel interfaces of the source tokenizer: the byte input channel and the
// token output channel, each with valid, ready and payload.
// No dependencies.
interface stu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       final_byte;

	modport source (output valid, output source_byte, output final_byte, input ready);
	modport sink (input valid, input source_byte, input final_byte, output ready);
endinterface

interface stu_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [2:0]  sub_code;
	logic [19:0] token_start;
	logic [20:0] token_length;
	logic [63:0] number_value;
	logic        last_of_run;

	modport source (output valid, output token_kind, output sub_code, output token_start,
		output token_length, output number_value, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input sub_code, input token_start,
		input token_length, input number_value, input last_of_run, output ready);
endinterface

// ===== rtl/stu_front.sv =====
// Front end of the source tokenizer: accepts bytes, runs the scanner state and
// builds the up to three tokens that each byte causes as one queue entry.
// Depends on stu_pkg and stu_if.
module stu_front #(
	parameter longint unsigned SOURCE_BYTES = stu_pkg::SOURCE_BYTES_DEF,
	parameter int unsigned KEYWORD_MAX_CHARS = stu_pkg::KW_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	stu_byte_if.sink      text,
	output stu_pkg::push_t push,
	input  logic          full
);
	import stu_pkg::*;

	localparam int POS_W = $clog2(SOURCE_BYTES);
	localparam int LEN_W = $clog2(SOURCE_BYTES + 1);
	localparam int KW_IW = $clog2(KEYWORD_MAX_CHARS);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(SOURCE_BYTES - 1);
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(SOURCE_BYTES);
	localparam logic [LEN_W-1:0] KW_CAP = LEN_W'(KEYWORD_MAX_CHARS);

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_IDENT = 2'd1;
	localparam logic [1:0] MODE_NUMBER = 2'd2;
	localparam logic [1:0] MODE_DROP = 2'd3;

	typedef logic [7:0] kw_arr_t [KEYWORD_MAX_CHARS];

	logic [1:0]       mode_q, mode_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] pstart_q, pstart_n;
	logic [LEN_W-1:0] plen_q, plen_n;
	logic [63:0]      acc_q, acc_n;
	kw_arr_t          kw_q, kw_n;

	logic       accept;
	logic [7:0] c;
	logic       fin;
	logic       is_digit, is_alpha, is_space, is_word;
	logic [3:0] digit;
	logic [67:0] prod;
	logic [LEN_W-1:0] grown;
	logic       taken;
	logic       p_hit;
	logic [3:0] p_kind;
	logic [2:0] p_sub;
	tok_t [2:0] slot;
	logic [1:0] n;

	function automatic tok_t make_tok(logic [3:0] kind, logic [2:0] sub,
		logic [POS_W-1:0] start, logic [LEN_W-1:0] len, logic [63:0] val);
		tok_t t;
		t.kind = kind;
		t.sub = sub;
		t.start = 20'(start);
		t.length = 21'(len);
		t.value = val;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic tok_t ident_tok(kw_arr_t kw, logic [LEN_W-1:0] len,
		logic [POS_W-1:0] start);
		tok_t t;
		logic hit;
		t = make_tok(TK_IDENT, SUB_NONE, start, len, 64'd0);
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (len == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_SPAN; i++) begin
				if (i < KW_LEN[k] && kw[i] != KW_TEXT[k][i]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				t.kind = TK_KEYWORD;
				t.sub = 3'(k);
			end
		end
		return t;
	endfunction

	assign text.ready = !full;
	assign accept = text.valid && text.ready;
	assign c = text.source_byte;
	assign fin = text.final_byte;

	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	assign is_word = is_alpha || is_digit || (c == "_");
	assign digit = c[3:0];
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(digit);
	assign grown = (plen_q < LEN_CAP) ? plen_q + 1'b1 : LEN_CAP;

	always_comb begin
		p_hit = 1'b1;
		p_kind = TK_OPER;
		p_sub = SUB_NONE;
		unique case (c)
			"+": p_sub = OP_PLUS;
			"-": p_sub = OP_MINUS;
			"*": p_sub = OP_MULT;
			"/": p_sub = OP_DIV;
			";": p_kind = TK_SEMI;
			"=": p_kind = TK_ASSIGN;
			"{": p_kind = TK_LCURLY;
			"}": p_kind = TK_RCURLY;
			"(": p_kind = TK_LPAREN;
			")": p_kind = TK_RPAREN;
			",": p_kind = TK_COMMA;
			"\"": p_kind = TK_QUOTE;
			default: p_hit = 1'b0;
		endcase
	end

	always_comb begin
		mode_n = mode_q;
		pos_n = pos_q;
		pstart_n = pstart_q;
		plen_n = plen_q;
		acc_n = acc_q;
		kw_n = kw_q;
		taken = 1'b0;
		slot = '0;
		n = 2'd0;

		unique case (mode_q)
			MODE_DROP: taken = 1'b1;
			MODE_IDENT: begin
				if (is_word) begin
					if (plen_q < KW_CAP) begin
						kw_n[plen_q[KW_IW-1:0]] = c;
					end
					plen_n = grown;
					taken = 1'b1;
				end else begin
					slot[n] = ident_tok(kw_q, plen_q, pstart_q);
					n = n + 2'd1;
					mode_n = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					acc_n = (|prod[67:64]) ? '1 : prod[63:0];
					plen_n = grown;
					taken = 1'b1;
				end else if (is_alpha) begin
					slot[n] = make_tok(TK_ERROR, SUB_NONE, pstart_q, plen_q, 64'd0);
					n = n + 2'd1;
					mode_n = MODE_DROP;
					taken = 1'b1;
				end else begin
					slot[n] = make_tok(TK_NUMBER, SUB_NONE, pstart_q, plen_q, acc_q);
					n = n + 2'd1;
					mode_n = MODE_IDLE;
				end
			end
			default: mode_n = MODE_IDLE;
		endcase

		if (!taken && !is_space) begin
			if (is_digit) begin
				mode_n = MODE_NUMBER;
				pstart_n = pos_q;
				plen_n = LEN_W'(1);
				acc_n = 64'(digit);
			end else if (is_alpha || c == "_") begin
				mode_n = MODE_IDENT;
				pstart_n = pos_q;
				plen_n = LEN_W'(1);
				kw_n[0] = c;
			end else if (p_hit) begin
				slot[n] = make_tok(p_kind, p_sub, pos_q, LEN_W'(1), 64'd0);
				n = n + 2'd1;
			end
		end

		if (fin) begin
			if (mode_n == MODE_IDENT) begin
				slot[n] = ident_tok(kw_n, plen_n, pstart_n);
				n = n + 2'd1;
			end else if (mode_n == MODE_NUMBER) begin
				slot[n] = make_tok(TK_NUMBER, SUB_NONE, pstart_n, plen_n, acc_n);
				n = n + 2'd1;
			end
			slot[n] = make_tok(TK_END, SUB_NONE, pos_q, '0, 64'd0);
			n = n + 2'd1;
			mode_n = MODE_IDLE;
			pos_n = '0;
			pstart_n = '0;
			plen_n = '0;
			acc_n = '0;
		end else if (pos_q < POS_LAST) begin
			pos_n = pos_q + 1'b1;
		end

		if (n != 2'd0) begin
			slot[n - 2'd1].last = 1'b1;
		end
	end

	assign push.valid = accept && (n != 2'd0);
	assign push.bundle.tok = slot;
	assign push.bundle.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			pstart_q <= pstart_n;
			plen_q <= plen_n;
			acc_q <= acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kw_q <= kw_n;
		end
	end

endmodule

// ===== rtl/stu_back.sv =====
// Back end of the source tokenizer: a short queue of per-byte token groups and
// the output register that hands the tokens out one per transaction.
// Depends on stu_pkg and stu_if.
module stu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  stu_pkg::push_t push,
	output logic          full,
	stu_token_if.source   tokens
);
	import stu_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	bundle_t          queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       idx_q;
	logic             out_vld_q;
	tok_t             out_tok_q;

	bundle_t head;
	logic    load, pop;

	assign head = queue_q[rd_ptr_q];
	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign load = (cnt_q != '0) && (!out_vld_q || tokens.ready);
	assign pop = load && (idx_q == head.count - 2'd1);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			queue_q[wr_ptr_q] <= push.bundle;
		end
		if (load) begin
			out_tok_q <= head.tok[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + CNT_W'(push.valid) - CNT_W'(pop);
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (tokens.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign tokens.valid = out_vld_q;
	assign tokens.token_kind = out_tok_q.kind;
	assign tokens.sub_code = out_tok_q.sub;
	assign tokens.token_start = out_tok_q.start;
	assign tokens.token_length = out_tok_q.length;
	assign tokens.number_value = out_tok_q.value;
	assign tokens.last_of_run = out_tok_q.last;

endmodule

// ===== rtl/source_tokenizer.sv =====
// Top level of the source tokenizer: front end, token queue and output stage.
// Depends on stu_pkg, stu_if, stu_front and stu_back.
//
// Source text enters on the text channel, one byte per transaction, with
// final_byte marking the last byte of a source. Tokens leave on the tokens
// channel, one per transaction, each with kind, sub code, start offset,
// length and, for numbers, the saturated decimal value; last_of_run marks the
// last token caused by one byte. A byte marked final flushes any pending token
// and yields an end token, after which offsets start again at zero.
// A byte is taken every cycle while the four-entry queue has room. The first
// token caused by a byte is written into a queue entry and then loaded into
// the output register; a byte that causes several tokens holds its entry
// until each of them has been loaded, so the queue drains at one token per
// cycle while the receiver is ready, and the input keeps one byte per cycle as
// long as the tokens average no more than one per byte.
// When the receiver stalls, the output register holds its token, the queue
// fills, and text.ready drops once all four entries are taken.
// Reset empties the queue, clears the output valid and returns the scanner to
// idle at offset zero; bytes are accepted as soon as reset is released.
module source_tokenizer #(
	parameter longint unsigned SOURCE_BYTES = stu_pkg::SOURCE_BYTES_DEF,
	parameter int unsigned KEYWORD_MAX_CHARS = stu_pkg::KW_MAX_DEF
) (
	input logic         clk,
	input logic         arst_n,
	stu_byte_if.sink    text,
	stu_token_if.source tokens
);
	import stu_pkg::*;

	push_t push;
	logic  full;

	stu_front #(
		.SOURCE_BYTES(SOURCE_BYTES),
		.KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.push(push),
		.full(full)
	);

	stu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tokens(tokens)
	);

endmodule

// ===== rtl/stu_checker.sv =====
// Port checker of the source tokenizer and the bind that attaches it to the
// top level. Depends on stu_pkg.
module stu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_ready,
	input logic [3:0]  tok_kind,
	input logic [20:0] tok_length,
	input logic [63:0] tok_value,
	input logic        tok_last
);
	import stu_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid)
		else $error("Token valid dropped before its transaction completed.");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> $stable(tok_kind) && $stable(tok_length)
			&& $stable(tok_value) && $stable(tok_last))
		else $error("Token payload changed while stalled.");

	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind == TK_END |-> tok_length == '0 && tok_last)
		else $error("End token is not a zero-length last token.");

	a_value_only_numbers: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind != TK_NUMBER |-> tok_value == '0)
		else $error("Non-number token carries a value.");

endmodule

bind source_tokenizer stu_checker u_stu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.tok_valid(tokens.valid),
	.tok_ready(tokens.ready),
	.tok_kind(tokens.token_kind),
	.tok_length(tokens.token_length),
	.tok_value(tokens.number_value),
	.tok_last(tokens.last_of_run)
);

// ===== bench/source_tokenizer_tb.sv =====
// Self-checking testbench of source_tokenizer: a queue-fed byte driver, a token monitor
// and a scanner predictor that holds the expected tokens.
// Depends on stu_pkg, stu_if and the source_tokenizer RTL.
module source_tokenizer_tb;
	import stu_pkg::*;

	localparam longint unsigned SRC_BYTES = 256;
	localparam int unsigned KW_CHARS = 7;
	localparam int unsigned HOLD_AT = 8;
	localparam int unsigned HOLD_CYCLES = 40;
	localparam int unsigned PAUSE_AT = 150;
	localparam int unsigned RANDOM_BYTES = 208;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_DROP} scan_mode_t;

	typedef struct packed {
		logic [7:0] c;
		logic       fin;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n;

	stu_byte_if text_ch();
	stu_token_if token_ch();

	source_tokenizer #(
		.SOURCE_BYTES(SRC_BYTES),
		.KEYWORD_MAX_CHARS(KW_CHARS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.tokens(token_ch)
	);

	always #5 clk = ~clk;

	text_item_t byte_queue[$];
	tok_t expected_tokens[$];
	tok_t run_toks[$];

	string kw_words[6] = '{"return", "let", "def", "if", "while", "__asm__"};

	scan_mode_t scan_st;
	int unsigned scan_pos;
	int unsigned pend_start;
	int unsigned pend_len;
	logic [7:0] kw_buf[KW_CHARS];
	longint unsigned num_acc;

	int unsigned sent_bytes = 0;
	int unsigned bytes_taken = 0;
	int unsigned predicted_total = 0;
	int unsigned tokens_seen = 0;
	int unsigned hold_left = 0;
	bit hold_done = 0;
	bit pausing = 0;
	bit pause_done = 0;
	int unsigned mismatches = 0;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int unsigned grow(int unsigned len);
		return len < SRC_BYTES ? len + 1 : int'(SRC_BYTES);
	endfunction

	function automatic void clear_scan();
		scan_st = SCAN_IDLE;
		scan_pos = 0;
		pend_start = 0;
		pend_len = 0;
		num_acc = 0;
		foreach (kw_buf[i])
			kw_buf[i] = 8'h00;
	endfunction

	function automatic void add_token(logic [3:0] kind, logic [2:0] sub, int unsigned start,
		int unsigned len, longint unsigned val);
		tok_t t;
		t.kind = kind;
		t.sub = sub;
		t.start = 20'(start);
		t.length = 21'(len);
		t.value = val;
		t.last = 1'b0;
		run_toks.push_back(t);
	endfunction

	function automatic void flush_word();
		bit hit;
		for (int k = 0; k < 6; k++) begin
			if (pend_len == kw_words[k].len()) begin
				hit = 1;
				for (int i = 0; i < kw_words[k].len(); i++)
					if (kw_buf[i] != kw_words[k][i])
						hit = 0;
				if (hit) begin
					add_token(TK_KEYWORD, 3'(k), pend_start, pend_len, 0);
					return;
				end
			end
		end
		add_token(TK_IDENT, SUB_NONE, pend_start, pend_len, 0);
	endfunction

	function automatic void begin_token(logic [7:0] c, int unsigned p);
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		if (is_digit(c)) begin
			scan_st = SCAN_NUMBER;
			pend_start = p;
			pend_len = 1;
			num_acc = c - 8'd48;
			return;
		end
		if (is_letter(c) || c == "_") begin
			scan_st = SCAN_WORD;
			pend_start = p;
			pend_len = 1;
			kw_buf[0] = c;
			return;
		end
		case (c)
			"+": add_token(TK_OPER, OP_PLUS, p, 1, 0);
			"-": add_token(TK_OPER, OP_MINUS, p, 1, 0);
			"*": add_token(TK_OPER, OP_MULT, p, 1, 0);
			"/": add_token(TK_OPER, OP_DIV, p, 1, 0);
			";": add_token(TK_SEMI, SUB_NONE, p, 1, 0);
			"=": add_token(TK_ASSIGN, SUB_NONE, p, 1, 0);
			"{": add_token(TK_LCURLY, SUB_NONE, p, 1, 0);
			"}": add_token(TK_RCURLY, SUB_NONE, p, 1, 0);
			"(": add_token(TK_LPAREN, SUB_NONE, p, 1, 0);
			")": add_token(TK_RPAREN, SUB_NONE, p, 1, 0);
			",": add_token(TK_COMMA, SUB_NONE, p, 1, 0);
			"\"": add_token(TK_QUOTE, SUB_NONE, p, 1, 0);
			default: ;
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] c, logic fin);
		int unsigned p;
		bit taken;
		longint unsigned d;
		p = scan_pos;
		taken = 0;
		run_toks.delete();
		case (scan_st)
			SCAN_DROP: taken = 1;
			SCAN_WORD: begin
				if (is_letter(c) || is_digit(c) || c == "_") begin
					if (pend_len < KW_CHARS)
						kw_buf[pend_len] = c;
					pend_len = grow(pend_len);
					taken = 1;
				end else begin
					flush_word();
					scan_st = SCAN_IDLE;
				end
			end
			SCAN_NUMBER: begin
				if (is_digit(c)) begin
					d = c - 8'd48;
					if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10)
						num_acc = 64'hFFFF_FFFF_FFFF_FFFF;
					else
						num_acc = num_acc * 10 + d;
					pend_len = grow(pend_len);
					taken = 1;
				end else if (is_letter(c)) begin
					add_token(TK_ERROR, SUB_NONE, pend_start, pend_len, 0);
					scan_st = SCAN_DROP;
					taken = 1;
				end else begin
					add_token(TK_NUMBER, SUB_NONE, pend_start, pend_len, num_acc);
					scan_st = SCAN_IDLE;
				end
			end
			default: ;
		endcase
		if (!taken)
			begin_token(c, p);
		if (fin) begin
			if (scan_st == SCAN_WORD)
				flush_word();
			else if (scan_st == SCAN_NUMBER)
				add_token(TK_NUMBER, SUB_NONE, pend_start, pend_len, num_acc);
			add_token(TK_END, SUB_NONE, p, 0, 0);
			clear_scan();
		end else if (p < SRC_BYTES - 1) begin
			scan_pos = p + 1;
		end
		if (run_toks.size() != 0)
			run_toks[run_toks.size() - 1].last = 1'b1;
		foreach (run_toks[i])
			expected_tokens.push_back(run_toks[i]);
		predicted_total += run_toks.size();
	endfunction

	function automatic int unsigned idle_share(int unsigned phase, bit rx);
		case (phase)
			0: return 0;
			1: return rx ? 0 : 45;
			2: return rx ? 45 : 0;
			default: return 37;
		endcase
	endfunction

	task automatic flag_error(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic push_one(logic [7:0] c, bit fin);
		text_item_t t;
		t.c = c;
		t.fin = fin;
		byte_queue.push_back(t);
	endtask

	task automatic push_text(string s, bit fin_last);
		for (int i = 0; i < s.len(); i++)
			push_one(s[i], fin_last && i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_letter();
		int unsigned r;
		r = $urandom_range(51);
		return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_word_char();
		int unsigned r;
		r = $urandom_range(62);
		if (r < 52)
			return rand_letter();
		return r < 62 ? 8'("0" + r - 52) : 8'("_");
	endfunction

	function automatic logic [7:0] rand_space();
		int unsigned r;
		r = $urandom_range(5);
		return r == 0 ? 8'd32 : 8'(8 + r);
	endfunction

	function automatic logic [7:0] rand_punct();
		string pun;
		pun = "+-*/;={}(),\"";
		return pun[$urandom_range(11)];
	endfunction

	task automatic add_word();
		int unsigned r;
		int unsigned k;
		int unsigned n;
		r = $urandom_range(99);
		k = $urandom_range(5);
		if (r < 35) begin
			push_text(kw_words[k], 0);
		end else if (r < 50) begin
			if ($urandom_range(1) && kw_words[k].len() > 1) begin
				push_text(kw_words[k].substr(0, kw_words[k].len() - 2), 0);
			end else begin
				push_text(kw_words[k], 0);
				push_one(rand_word_char(), 0);
			end
		end else begin
			push_one($urandom_range(9) == 0 ? 8'("_") : rand_letter(), 0);
			n = $urandom_range(7) == 0 ? $urandom_range(14, 7) : $urandom_range(6);
			repeat (n)
				push_one(rand_word_char(), 0);
		end
	endtask

	task automatic add_number();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			push_text("18446744073709551615", 0);
		else if (r < 20)
			push_text("18446744073709551616", 0);
		else
			repeat ($urandom_range(r < 45 ? 24 : 4, 1))
				push_one(8'("0" + $urandom_range(9)), 0);
	endtask

	task automatic add_source();
		int unsigned r;
		int unsigned n;
		n = $urandom_range(6, 1);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 40) begin
				add_word();
			end else if (r < 70) begin
				add_number();
				r = $urandom_range(99);
				if (r < 12)
					push_one(rand_letter(), 0);
				else if (r < 20)
					push_one("_", 0);
			end else if (r < 90) begin
				push_one(rand_punct(), 0);
			end else begin
				push_one(8'($urandom_range(255)), 0);
			end
			r = $urandom_range(99);
			if (r < 50)
				repeat ($urandom_range(2, 1))
					push_one(rand_space(), 0);
			else if (r < 75)
				push_one(rand_punct(), 0);
			else if (r < 90)
				;
			else
				push_one(8'($urandom_range(255)), 0);
		end
		case ($urandom_range(4))
			0: push_one(rand_word_char(), 1);
			1: push_one(8'("0" + $urandom_range(9)), 1);
			2: push_one(rand_punct(), 1);
			3: push_one(rand_space(), 1);
			default: push_one(8'($urandom_range(255)), 1);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.source_byte <= 8'h00;
			text_ch.final_byte <= 1'b0;
		end else begin : drive
			bit fire;
			bit offer;
			text_item_t nxt;
			fire = text_ch.valid && text_ch.ready;
			if (fire) begin
				predict_byte(text_ch.source_byte, text_ch.final_byte);
				sent_bytes++;
			end
			if (!pause_done && sent_bytes >= PAUSE_AT) begin
				pausing = 1;
				pause_done = 1;
			end
			if (pausing && predicted_total == tokens_seen)
				pausing = 0;
			if (!text_ch.valid || fire) begin
				offer = byte_queue.size() != 0 && !pausing
					&& $urandom_range(99) >= idle_share(sent_bytes / 64 % 4, 0);
				text_ch.valid <= offer;
				if (offer) begin
					nxt = byte_queue.pop_front();
					text_ch.source_byte <= nxt.c;
					text_ch.final_byte <= nxt.fin;
				end
			end
			bytes_taken <= sent_bytes;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 0;
		end else if (!hold_done && bytes_taken >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ch.ready <= 1'b0;
			tokens_seen <= 0;
		end else begin : watch
			tok_t want;
			if (token_ch.valid && token_ch.ready) begin
				tokens_seen <= tokens_seen + 1;
				if (expected_tokens.size() == 0) begin
					flag_error($sformatf("token with no expectation: kind %0d start %0d",
						token_ch.token_kind, token_ch.token_start));
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", token_ch.token_kind, want.kind);
					check_field("sub_code", token_ch.sub_code, want.sub);
					check_field("token_start", token_ch.token_start, want.start);
					check_field("token_length", token_ch.token_length, want.length);
					check_field("number_value", token_ch.number_value, want.value);
					check_field("last_of_run", token_ch.last_of_run, want.last);
				end
			end
			token_ch.ready <= hold_left == 0
				&& $urandom_range(99) >= idle_share(bytes_taken / 64 % 4, 1);
		end
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.source_byte = 8'h00;
		text_ch.final_byte = 1'b0;
		token_ch.ready = 1'b0;
		clear_scan();

		push_text("+-*/;={}(),\"", 1);
		push_one(8'h00, 0);
		push_one(8'hFF, 0);
		push_text(" 12a3 z", 1);
		push_text("7_if", 1);
		while (byte_queue.size() < RANDOM_BYTES)
			add_source();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || text_ch.valid)
			@(negedge clk);
		while (expected_tokens.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
